// File: hw/rtl/b64rle_pkg.sv
// shared types, constants and helper functions of the base64 escape rle decoder
package b64rle_pkg;

    localparam int LEN_W      = 35;
    localparam int MAX_GROUPS = 5;
    localparam int GROUP_BITS = 7;
    localparam int GRP_W      = $clog2(MAX_GROUPS + 1);
    localparam int WIDE_W     = ((GROUP_BITS * MAX_GROUPS > LEN_W) ?
                                 GROUP_BITS * MAX_GROUPS : LEN_W) + 1;

    localparam logic [LEN_W-1:0] LEN_MAX       = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] MAX_RUN_RESET = LEN_W'(64'h4000_0000);

    localparam logic [7:0] ESC_BYTE  = 8'hFE;
    localparam logic [7:0] CHR_EQUAL = 8'h3D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [5:0] SYM_PLUS  = 6'd62;
    localparam logic [5:0] SYM_SLASH = 6'd63;

    // status codes
    localparam logic [2:0] ST_RUNNING = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_BAD     = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_OVER    = 3'd4;

    // config register indexes
    localparam logic CFG_MAX_RUN    = 1'b0;
    localparam logic CFG_ACCEPT_OVR = 1'b1;

    // queue token kinds
    localparam logic [1:0] TK_BYTE      = 2'd0;
    localparam logic [1:0] TK_BAD       = 2'd1;
    localparam logic [1:0] TK_END       = 2'd2;
    localparam logic [1:0] TK_END_QUIET = 2'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } token_t;

    typedef struct packed {
        logic             run_valid;
        logic [7:0]       run_value;
        logic [LEN_W-1:0] run_length;
        logic             oversize_seen;
        logic [2:0]       status;
        logic             final_res;
    } run_t;

    // base64 symbol value, bit 6 set when the character is a symbol
    function automatic logic [6:0] sym_decode(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = {1'b1, 6'(c - 8'h41)};
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            r = {1'b1, 6'(c - 8'h61 + 8'd26)};
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            r = {1'b1, 6'(c - 8'h30 + 8'd52)};
        end
        else if (c == 8'h2B)
        begin
            r = {1'b1, SYM_PLUS};
        end
        else if (c == 8'h2F)
        begin
            r = {1'b1, SYM_SLASH};
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    endfunction

endpackage

// File: hw/rtl/b64rle_if.sv
// valid/ready channel interfaces for text characters and run descriptors
interface b64rle_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_marker;

    modport source (output valid, output text_char, output end_marker, input ready);
    modport sink   (input valid, input text_char, input end_marker, output ready);
endinterface

interface b64rle_run_if;
    import b64rle_pkg::*;
    logic             valid;
    logic             ready;
    logic             run_valid;
    logic [7:0]       run_value;
    logic [LEN_W-1:0] run_length;
    logic             oversize_seen;
    logic [2:0]       status;
    logic             final_res;

    modport source (output valid, output run_valid, output run_value, output run_length,
                    output oversize_seen, output status, output final_res, input ready);
    modport sink   (input valid, input run_valid, input run_value, input run_length,
                    input oversize_seen, input status, input final_res, output ready);
endinterface

// File: hw/rtl/b64rle_fifo.sv
// short token queue between the character front end and the run decoder
module b64rle_fifo
    import b64rle_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  token_t push_token,
    input  logic   pop,
    output token_t pop_token,
    output logic   full,
    output logic   empty
);

    token_t           entry_reg [FIFO_DEPTH];
    logic [PTR_W:0]   wr_ptr_reg;
    logic [PTR_W:0]   wr_ptr_next;
    logic [PTR_W:0]   rd_ptr_reg;
    logic [PTR_W:0]   rd_ptr_next;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]) &&
                   (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]);
    assign pop_token   = entry_reg[rd_ptr_reg[PTR_W-1:0]];
    assign wr_ptr_next = wr_ptr_reg + (PTR_W+1)'(1);
    assign rd_ptr_next = rd_ptr_reg + (PTR_W+1)'(1);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg[PTR_W-1:0]] <= push_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

endmodule

// File: hw/rtl/b64rle_front.sv
// character front end: whitespace and line skipping, base64 bit packing
module b64rle_front
    import b64rle_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    b64rle_char_if.sink chars,
    input  logic   queue_full,
    output logic   push,
    output token_t push_token
);

    logic [5:0]  residue_reg;
    logic [5:0]  residue_next;
    logic [2:0]  count_reg;
    logic [2:0]  count_next;
    logic        skip_reg;
    logic        skip_next;
    logic        stopped_reg;
    logic        stopped_next;

    logic        accept;
    logic [6:0]  sym;
    logic [11:0] acc;
    logic [3:0]  nbits;
    logic [2:0]  sh;

    assign chars.ready = !queue_full;
    assign accept      = chars.valid && !queue_full;
    assign sym         = sym_decode(chars.text_char);
    assign acc         = {residue_reg, sym[5:0]};
    assign nbits       = {1'b0, count_reg} + 4'd6;
    assign sh          = 3'(nbits - 4'd8);

    always_comb
    begin
        residue_next = residue_reg;
        count_next   = count_reg;
        skip_next    = skip_reg;
        stopped_next = stopped_reg;
        push         = 1'b0;
        push_token   = '{kind: TK_BYTE, data: 8'h00};
        if (accept)
        begin
            if (chars.end_marker)
            begin
                push            = 1'b1;
                push_token.kind = stopped_reg ? TK_END_QUIET : TK_END;
                residue_next    = '0;
                count_next      = '0;
                skip_next       = 1'b0;
                stopped_next    = 1'b0;
            end
            else if (stopped_reg)
            begin
                // drop everything until the end of the dump
            end
            else if (skip_reg)
            begin
                if (chars.text_char == CHR_LF)
                begin
                    skip_next = 1'b0;
                end
            end
            else if (is_blank(chars.text_char))
            begin
            end
            else if (chars.text_char == CHR_EQUAL)
            begin
                skip_next = 1'b1;
            end
            else if (!sym[6])
            begin
                push            = 1'b1;
                push_token.kind = TK_BAD;
                stopped_next    = 1'b1;
            end
            else if (nbits >= 4'd8)
            begin
                push            = 1'b1;
                push_token.data = 8'(acc >> sh);
                residue_next    = 6'(acc & ((12'd1 << sh) - 12'd1));
                count_next      = sh;
            end
            else
            begin
                residue_next = acc[5:0];
                count_next   = nbits[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            residue_reg <= '0;
            count_reg   <= '0;
            skip_reg    <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            residue_reg <= residue_next;
            count_reg   <= count_next;
            skip_reg    <= skip_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// File: hw/rtl/b64rle_back.sv
// run decoder: escape and varint count handling, config registers, output register
module b64rle_back
    import b64rle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             queue_empty,
    input  token_t           token,
    output logic             pop,
    b64rle_run_if.source     runs
);

    localparam logic [1:0] PH_LIT = 2'd0;
    localparam logic [1:0] PH_CNT = 2'd1;
    localparam logic [1:0] PH_VAL = 2'd2;

    logic [LEN_W-1:0]  max_run_reg;
    logic              accept_ovr_reg;

    logic [1:0]        phase_reg;
    logic [1:0]        phase_next;
    logic [LEN_W-1:0]  count_reg;
    logic [LEN_W-1:0]  count_next;
    logic [GRP_W-1:0]  grp_reg;
    logic [GRP_W-1:0]  grp_next;
    logic              over_reg;
    logic              over_next;
    logic              stopped_reg;
    logic              stopped_next;
    logic              out_valid_reg;
    run_t              out_reg;
    run_t              out_next;
    logic              load_out;

    logic [WIDE_W-1:0] shifted;
    logic [LEN_W-1:0]  count_add;
    logic              count_big;
    logic              count_big_now;

    assign pop = !queue_empty && (!out_valid_reg || runs.ready);

    // group placed at its 7-bit position, saturating when it overflows the length
    assign shifted   = {{(WIDE_W-GROUP_BITS){1'b0}}, token.data[GROUP_BITS-1:0]}
                       << (GROUP_BITS * grp_reg);
    assign count_add = (shifted[WIDE_W-1:LEN_W] != '0) ? LEN_MAX
                                                       : (count_reg | shifted[LEN_W-1:0]);
    assign count_big     = count_next > max_run_reg;
    assign count_big_now = count_reg > max_run_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        grp_next     = grp_reg;
        over_next    = over_reg;
        stopped_next = stopped_reg;
        load_out     = 1'b0;
        out_next     = '{run_valid: 1'b0, run_value: 8'h00, run_length: '0,
                         oversize_seen: 1'b0, status: ST_RUNNING, final_res: 1'b0};
        if (pop)
        begin
            case (token.kind)
                TK_END, TK_END_QUIET:
                begin
                    load_out           = !stopped_reg && (token.kind == TK_END);
                    out_next.final_res = 1'b1;
                    case (phase_reg)
                        PH_CNT:  out_next.status = (count_big_now && !accept_ovr_reg) ?
                                                   ST_OVER : ST_TRUNC;
                        PH_VAL:  out_next.status = ST_TRUNC;
                        default: out_next.status = ST_OK;
                    endcase
                    phase_next   = PH_LIT;
                    count_next   = '0;
                    grp_next     = '0;
                    over_next    = 1'b0;
                    stopped_next = 1'b0;
                end
                TK_BAD:
                begin
                    if (!stopped_reg)
                    begin
                        load_out           = 1'b1;
                        out_next.status    = ST_BAD;
                        out_next.final_res = 1'b1;
                        stopped_next       = 1'b1;
                    end
                end
                default:
                begin
                    if (!stopped_reg)
                    begin
                        case (phase_reg)
                            PH_CNT:
                            begin
                                if (grp_reg < GRP_W'(MAX_GROUPS))
                                begin
                                    count_next = count_add;
                                    grp_next   = grp_reg + GRP_W'(1);
                                end
                                if (!token.data[7])
                                begin
                                    if (count_big && !accept_ovr_reg)
                                    begin
                                        load_out           = 1'b1;
                                        out_next.status    = ST_OVER;
                                        out_next.final_res = 1'b1;
                                        stopped_next       = 1'b1;
                                    end
                                    else
                                    begin
                                        over_next  = over_reg || count_big;
                                        phase_next = PH_VAL;
                                    end
                                end
                            end
                            PH_VAL:
                            begin
                                load_out               = 1'b1;
                                out_next.run_valid     = 1'b1;
                                out_next.run_value     = token.data;
                                out_next.run_length    = count_reg;
                                out_next.oversize_seen = over_reg;
                                phase_next             = PH_LIT;
                                count_next             = '0;
                                grp_next               = '0;
                                over_next              = 1'b0;
                            end
                            default:
                            begin
                                if (token.data == ESC_BYTE)
                                begin
                                    phase_next = PH_CNT;
                                    count_next = '0;
                                    grp_next   = '0;
                                    over_next  = 1'b0;
                                end
                                else
                                begin
                                    load_out            = 1'b1;
                                    phase_next          = PH_LIT;
                                    out_next.run_valid  = 1'b1;
                                    out_next.run_value  = token.data;
                                    out_next.run_length = LEN_W'(1);
                                end
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_run_reg    <= MAX_RUN_RESET;
            accept_ovr_reg <= 1'b0;
            phase_reg      <= PH_LIT;
            count_reg      <= '0;
            grp_reg        <= '0;
            over_reg       <= 1'b0;
            stopped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_MAX_RUN:    max_run_reg    <= cfg_wr_data;
                    CFG_ACCEPT_OVR: accept_ovr_reg <= cfg_wr_data[0];
                    default:        ;
                endcase
            end
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            grp_reg     <= grp_next;
            over_reg    <= over_next;
            stopped_reg <= stopped_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (runs.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign runs.valid         = out_valid_reg;
    assign runs.run_valid     = out_reg.run_valid;
    assign runs.run_value     = out_reg.run_value;
    assign runs.run_length    = out_reg.run_length;
    assign runs.oversize_seen = out_reg.oversize_seen;
    assign runs.status        = out_reg.status;
    assign runs.final_res     = out_reg.final_res;

endmodule

// File: hw/rtl/base64_escape_rle_decoder.sv
// top level of the base64 escape rle decoder
// usage:
// - chars: one text character per request (text_char, end_marker); end_marker
//   closes the dump and its character is ignored
// - runs: one run descriptor per request; literals come out with length 1,
//   escaped runs as (value, count) without expansion; errors and the end of
//   a dump give a request with run_valid low, a status code and final_res set
// - cfg: cfg_wr_en with cfg_index 0 sets max_run_length, 1 sets
//   accept_oversize; write only while no dump data is in flight
// - throughput: one character per cycle, sustained while runs.ready stays high
// - path: the front end writes the token of an accepted character into the
//   queue, and the run decoder pops it and loads the output register once
//   the tokens ahead of it are gone and the output register can take it
// - reset: max_run_length returns to 0x40000000, accept_oversize to 0,
//   all decoder state is cleared and the queue is emptied
// - stall: while runs.ready is low the output register holds; the four-entry
//   token queue keeps filling and chars.ready drops once it is full
// - after an error the dump is dropped until end_marker, which gives no result
module base64_escape_rle_decoder
    import b64rle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    b64rle_char_if.sink      chars,
    b64rle_run_if.source     runs,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [LEN_W-1:0] cfg_wr_data
);

    // front end to queue
    logic   fifo_push;
    token_t fifo_in;
    logic   fifo_full;

    // queue to run decoder
    logic   fifo_pop;
    token_t fifo_out;
    logic   fifo_empty;

    // classifies characters and packs 6-bit symbols into bytes
    b64rle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .queue_full (fifo_full),
        .push       (fifo_push),
        .push_token (fifo_in)
    );

    // decouples the character side from output stalls
    b64rle_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fifo_push),
        .push_token (fifo_in),
        .pop        (fifo_pop),
        .pop_token  (fifo_out),
        .full       (fifo_full),
        .empty      (fifo_empty)
    );

    // escape/count decoding and the registered output
    b64rle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .queue_empty (fifo_empty),
        .token       (fifo_out),
        .pop         (fifo_pop),
        .runs        (runs)
    );

`ifndef SYNTH
    // the front end never writes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_push |-> !fifo_full)
        else $error("token pushed into full queue");

    // the decoder drains the queue whenever the output register can take a result
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!fifo_empty && (!runs.valid || runs.ready)) |-> fifo_pop)
        else $error("queue not drained");

    // a decoded run is never a final result and always carries running status
    a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
        (runs.valid && runs.run_valid) |-> (!runs.final_res && runs.status == ST_RUNNING))
        else $error("run with final or error status");

    // a result without a run always closes the dump
    a_final: assert property (@(posedge clk) disable iff (!rst_n)
        (runs.valid && !runs.run_valid) |-> (runs.final_res && runs.status != ST_RUNNING))
        else $error("empty result not final");
`endif

endmodule

// File: verif/base64_escape_rle_decoder_tb.sv
// self-checking testbench of the base64 escape rle decoder: directed table, then random dumps
`timescale 1ns / 100ps

module base64_escape_rle_decoder_tb;
    import b64rle_pkg::*;

    localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
    localparam int TEXT_ITEMS  = 1850;     // character requests to send
    localparam int MAX_REPORTS = 10;
    localparam int SETTLE      = 10;       // cycles for in-flight characters that give no run

    // escape decoder phase of the predictor
    typedef enum logic [1:0] {
        RP_LITERAL = 2'd0,
        RP_COUNT   = 2'd1,
        RP_VALUE   = 2'd2
    } rle_phase_e;

    // run channel stall patterns
    typedef enum logic [1:0] {
        RDY_ALWAYS   = 2'd0,
        RDY_COIN     = 2'd1,
        RDY_PERIODIC = 2'd2,
        RDY_BURSTY   = 2'd3
    } ready_mode_e;

    // one character request, with an optional run typed in by hand
    typedef struct packed {
        logic [7:0] ch;
        logic       eod;
        logic       typed;
        run_t       want;
    } text_row_t;

    // hand-typed runs for the directed table
    localparam run_t LIT_FF    = '{1'b1, 8'hFF, 35'd1, 1'b0, ST_RUNNING, 1'b0};
    localparam run_t LIT_00    = '{1'b1, 8'h00, 35'd1, 1'b0, ST_RUNNING, 1'b0};
    localparam run_t END_OK    = '{1'b0, 8'h00, 35'd0, 1'b0, ST_OK, 1'b1};
    localparam run_t ERR_BAD   = '{1'b0, 8'h00, 35'd0, 1'b0, ST_BAD, 1'b1};
    localparam run_t ERR_TRUNC = '{1'b0, 8'h00, 35'd0, 1'b0, ST_TRUNC, 1'b1};
    localparam run_t NO_RUN    = '0;

    localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    // directed table: literals at both byte extremes, blanks, a comment line with
    // junk in it, bad characters 0x00 and 0xFF, characters dropped while stopped,
    // a quiet end after an error, a zero-length run and an escape cut off by the end
    text_row_t dir_rows [0:22] = '{
        '{8'h2F, 1'b0, 1'b0, NO_RUN},     // '/'
        '{8'h77, 1'b0, 1'b1, LIT_FF},     // 'w' completes 0xFF
        '{8'hA5, 1'b1, 1'b1, END_OK},     // end, character ignored
        '{8'h20, 1'b0, 1'b0, NO_RUN},
        '{8'h09, 1'b0, 1'b0, NO_RUN},
        '{8'h3D, 1'b0, 1'b0, NO_RUN},     // '=' starts a comment
        '{8'hFF, 1'b0, 1'b0, NO_RUN},     // skipped inside the comment
        '{8'h0A, 1'b0, 1'b0, NO_RUN},     // line feed closes it
        '{8'h41, 1'b0, 1'b0, NO_RUN},
        '{8'h41, 1'b0, 1'b1, LIT_00},     // "AA" completes 0x00
        '{8'h00, 1'b0, 1'b1, ERR_BAD},
        '{8'h41, 1'b0, 1'b0, NO_RUN},     // stopped, dropped
        '{8'hFF, 1'b1, 1'b0, NO_RUN},     // end after an error gives nothing
        '{8'hFF, 1'b0, 1'b1, ERR_BAD},
        '{8'h00, 1'b1, 1'b0, NO_RUN},
        '{8'h2F, 1'b0, 1'b0, NO_RUN},     // "/gBB" = FE 00 41, zero count run
        '{8'h67, 1'b0, 1'b0, NO_RUN},
        '{8'h42, 1'b0, 1'b0, NO_RUN},
        '{8'h42, 1'b0, 1'b0, NO_RUN},
        '{8'h2F, 1'b0, 1'b0, NO_RUN},     // "/oU" = FE 85, count left open
        '{8'h6F, 1'b0, 1'b0, NO_RUN},
        '{8'h55, 1'b0, 1'b0, NO_RUN},
        '{8'h0A, 1'b1, 1'b1, ERR_TRUNC}
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic             cfg_index;
    logic [LEN_W-1:0] cfg_wr_data;

    b64rle_char_if chars_if ();
    b64rle_run_if  runs_if ();

    base64_escape_rle_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .chars       (chars_if),
        .runs        (runs_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // predictor state, a copy of what the decoder keeps
    logic [5:0]       b64_residue;
    int               b64_nbits;
    bit               skip_to_lf;
    rle_phase_e       esc_phase;
    logic [LEN_W-1:0] run_cnt;
    int               grp_idx;
    bit               halted;
    bit               over_flag;
    logic [LEN_W-1:0] lim_max;
    bit               lim_accept;

    // expected runs, oldest first, and the rows in flight on the character channel
    run_t      run_expect_q [$];
    text_row_t sent_q [$];

    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    int          text_items = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b0;
    ready_mode_e ready_mode = RDY_ALWAYS;
    int          stall_left = 0;
    int          ready_tick = 0;

    // text encoder of the stimulus side
    logic [15:0] enc_acc;
    int          enc_bits;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic bit is_space(input logic [7:0] c);
        foreach (BLANKS[i])
        begin
            if (c == BLANKS[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // 6-bit value of a base64 symbol, -1 for anything else
    function automatic int b64_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return int'(c) - int'("A");
        if (c >= "a" && c <= "z")
            return int'(c) - int'("a") + 26;
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0") + 52;
        if (c == "+")
            return int'(SYM_PLUS);
        if (c == "/")
            return int'(SYM_SLASH);
        return -1;
    endfunction

    task automatic clear_decoder();
        b64_residue = '0;
        b64_nbits   = 0;
        skip_to_lf  = 1'b0;
        esc_phase   = RP_LITERAL;
        run_cnt     = '0;
        grp_idx     = 0;
        halted      = 1'b0;
        over_flag   = 1'b0;
    endtask

    // error run, the dump is dropped until its end
    task automatic abort_dump(input logic [2:0] st, output bit hit, output run_t res);
        res           = '0;
        res.status    = st;
        res.final_res = 1'b1;
        hit           = 1'b1;
        halted        = 1'b1;
    endtask

    // one packed byte through the escape / count / value decoder
    task automatic feed_byte(input logic [7:0] b, output bit hit, output run_t res);
        logic [63:0] grp;
        hit = 1'b0;
        res = '0;
        case (esc_phase)
            RP_COUNT:
            begin
                // groups past the first MAX_GROUPS are eaten but not added
                if (grp_idx < MAX_GROUPS)
                begin
                    grp = 64'(b[6:0]) << (GROUP_BITS * grp_idx);
                    if (b[6:0] != 7'd0)
                    begin
                        if (GROUP_BITS * grp_idx >= LEN_W || grp > 64'(LEN_MAX))
                            run_cnt = LEN_MAX;
                        else
                            run_cnt |= LEN_W'(grp);
                    end
                    grp_idx++;
                end
                if (!b[7])
                begin
                    if (run_cnt > lim_max)
                    begin
                        if (!lim_accept)
                        begin
                            abort_dump(ST_OVER, hit, res);
                            return;
                        end
                        over_flag = 1'b1;
                    end
                    esc_phase = RP_VALUE;
                end
            end
            RP_VALUE:
            begin
                hit               = 1'b1;
                res.run_valid     = 1'b1;
                res.run_value     = b;
                res.run_length    = run_cnt;
                res.oversize_seen = over_flag;
                res.status        = ST_RUNNING;
                esc_phase         = RP_LITERAL;
                run_cnt           = '0;
                grp_idx           = 0;
                over_flag         = 1'b0;
            end
            default:
            begin
                if (b == ESC_BYTE)
                begin
                    esc_phase = RP_COUNT;
                    run_cnt   = '0;
                    grp_idx   = 0;
                    over_flag = 1'b0;
                end
                else
                begin
                    hit            = 1'b1;
                    res.run_valid  = 1'b1;
                    res.run_value  = b;
                    res.run_length = LEN_W'(1);
                    res.status     = ST_RUNNING;
                end
            end
        endcase
    endtask

    // one character request: returns whether it yields a run, and the run
    task automatic decode_char(input logic [7:0] ch, input logic eod,
                               output bit hit, output run_t res);
        logic [2:0]  st;
        bit          was_halted;
        int          sym;
        logic [11:0] acc;
        int          n;
        hit = 1'b0;
        res = '0;
        if (eod)
        begin
            // end of dump: status depends on where the escape decoder stands
            st = ST_OK;
            if (esc_phase == RP_COUNT)
                st = (run_cnt > lim_max && !lim_accept) ? ST_OVER : ST_TRUNC;
            else if (esc_phase == RP_VALUE)
                st = ST_TRUNC;
            was_halted = halted;
            clear_decoder();
            if (!was_halted)
            begin
                hit           = 1'b1;
                res.status    = st;
                res.final_res = 1'b1;
            end
            return;
        end
        if (halted)
            return;
        if (skip_to_lf)
        begin
            if (ch == CHR_LF)
                skip_to_lf = 1'b0;
            return;
        end
        if (is_space(ch))
            return;
        if (ch == CHR_EQUAL)
        begin
            skip_to_lf = 1'b1;
            return;
        end
        sym = b64_value(ch);
        if (sym < 0)
        begin
            abort_dump(ST_BAD, hit, res);
            return;
        end
        // pack msb first, a byte falls out every time 8 bits are gathered
        acc = {b64_residue, 6'(sym)};
        n   = b64_nbits + 6;
        if (n >= 8)
        begin
            n           -= 8;
            b64_residue = 6'(acc & ((12'd1 << n) - 12'd1));
            b64_nbits   = n;
            feed_byte(8'(acc >> n), hit, res);
        end
        else
        begin
            b64_residue = 6'(acc);
            b64_nbits   = n;
        end
    endtask

    // ------------------------------------------------------------------
    // monitors
    // ------------------------------------------------------------------

    // every accepted character request goes through the predictor; a typed row
    // supplies its own run instead
    always @(posedge clk)
    begin : predict_on_accept
        text_row_t row;
        bit        hit;
        run_t      res;
        if (rst_n && chars_if.valid && chars_if.ready)
        begin
            row = sent_q.pop_front();
            decode_char(chars_if.text_char, chars_if.end_marker, hit, res);
            if (row.typed)
                run_expect_q.insert(run_expect_q.size(), row.want);
            else if (hit)
                run_expect_q.insert(run_expect_q.size(), res);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
                $display("mismatch on %s: expected %0h, got %0h", name, want_v, got_v);
        end
    endtask

    // each run request is held against the oldest expected run
    always @(posedge clk)
    begin : check_runs
        run_t want;
        if (rst_n && runs_if.valid && runs_if.ready)
        begin
            if (run_expect_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS)
                    $display("mismatch: run with none expected, status %0d value %0h",
                             runs_if.status, runs_if.run_value);
            end
            else
            begin
                want = run_expect_q.pop_front();
                check_field("run_valid", 64'(want.run_valid), 64'(runs_if.run_valid));
                check_field("run_value", 64'(want.run_value), 64'(runs_if.run_value));
                check_field("run_length", 64'(want.run_length), 64'(runs_if.run_length));
                check_field("oversize_seen", 64'(want.oversize_seen),
                            64'(runs_if.oversize_seen));
                check_field("status", 64'(want.status), 64'(runs_if.status));
                check_field("final_res", 64'(want.final_res), 64'(runs_if.final_res));
            end
        end
    end

    // run channel back-pressure, pattern picked per phase
    always @(posedge clk)
    begin
        case (ready_mode)
            RDY_ALWAYS:   runs_if.ready <= 1'b1;
            RDY_COIN:     runs_if.ready <= 1'($urandom_range(0, 1));
            RDY_PERIODIC: runs_if.ready <= (ready_tick % 7) < 4;
            default:
            begin
                // mostly ready, with occasional long stalls
                if (stall_left > 0)
                begin
                    stall_left--;
                    runs_if.ready <= 1'b0;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    stall_left = $urandom_range(3, 15);
                    runs_if.ready <= 1'b0;
                end
                else
                begin
                    runs_if.ready <= 1'b1;
                end
            end
        endcase
        ready_tick++;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // one character request; with gaps_on the sender works in bursts with idle gaps between
    task automatic send_item(input text_row_t row);
        if (gaps_on && burst_left == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        sent_q.insert(sent_q.size(), row);
        text_items++;
        chars_if.valid      <= 1'b1;
        chars_if.text_char  <= row.ch;
        chars_if.end_marker <= row.eod;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_text(input logic [7:0] ch, input logic eod);
        text_row_t row;
        row       = '0;
        row.ch    = ch;
        row.eod   = eod;
        send_item(row);
    endtask

    // hold the character channel until every expected run is out and the
    // pipeline has emptied
    task automatic drain();
        chars_if.valid <= 1'b0;
        // let the predictor see the last accepted request first
        @(posedge clk);
        while (run_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // both registers back to back, only while the decoder is idle
    task automatic set_config(input logic [LEN_W-1:0] max_len, input logic accept);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_MAX_RUN;
        cfg_wr_data <= max_len;
        @(posedge clk);
        cfg_index   <= CFG_ACCEPT_OVR;
        cfg_wr_data <= LEN_W'(accept);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
        lim_max    = max_len;
        lim_accept = accept;
    endtask

    function automatic logic [7:0] sym_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'("A") + 8'(v);
        if (v < 6'd52)
            return 8'("a") + 8'(v - 6'd26);
        if (v < 6'd62)
            return 8'("0") + 8'(v - 6'd52);
        return (v == SYM_PLUS) ? 8'("+") : 8'("/");
    endfunction

    // one symbol, now and then preceded by a blank or a whole comment line
    task automatic push_sym(input logic [5:0] v);
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 59);
        if (r < 4)
        begin
            send_text(BLANKS[$urandom_range(0, 5)], 1'b0);
        end
        else if (r == 4)
        begin
            send_text(CHR_EQUAL, 1'b0);
            repeat ($urandom_range(0, 6))
            begin
                c = 8'($urandom);
                if (c == CHR_LF)
                    c = 8'h2A;
                send_text(c, 1'b0);
            end
            send_text(CHR_LF, 1'b0);
        end
        send_text(sym_char(v), 1'b0);
    endtask

    task automatic push_byte(input logic [7:0] b);
        enc_acc  = (enc_acc << 8) | 16'(b);
        enc_bits += 8;
        while (enc_bits >= 6)
        begin
            enc_bits -= 6;
            push_sym(6'(enc_acc >> enc_bits));
        end
        enc_acc &= (16'd1 << enc_bits) - 16'd1;
    endtask

    // one dump: mostly well-formed runs, some raw noise, stray characters and
    // escapes cut short by the end marker
    task automatic gen_dump();
        int         kind;
        int         n_runs;
        int         n_grp;
        logic [7:0] b;
        kind     = $urandom_range(0, 99);
        enc_acc  = '0;
        enc_bits = 0;
        if (kind < 12)
        begin
            repeat ($urandom_range(1, 12))
                send_text(8'($urandom), 1'b0);
        end
        else
        begin
            n_runs = $urandom_range(0, 10);
            for (int k = 0; k < n_runs; k++)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    b = 8'($urandom);
                    if (b == ESC_BYTE)
                        b ^= 8'h01;
                    push_byte(b);
                end
                else
                begin
                    // escape: count groups, at times more than are kept
                    push_byte(ESC_BYTE);
                    n_grp = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 7)
                                                        : $urandom_range(1, 3);
                    for (int g = 0; g < n_grp; g++)
                    begin
                        b = ($urandom_range(0, 3) == 0) ? 8'h7F : 8'($urandom_range(0, 127));
                        if (g != n_grp - 1)
                            b[7] = 1'b1;
                        push_byte(b);
                    end
                    push_byte(8'($urandom));
                end
                if ($urandom_range(0, 39) == 0)
                    send_text(8'($urandom), 1'b0);
            end
            // broken tail: the dump ends inside an escape
            if (kind < 24)
            begin
                push_byte(ESC_BYTE);
                if ($urandom_range(0, 1) == 1)
                    push_byte(8'h80 | 8'($urandom_range(0, 127)));
            end
            // leftover bits padded out to a whole symbol, never a whole byte
            if (enc_bits > 0)
                push_sym(6'(enc_acc << (6 - enc_bits)));
        end
        send_text(8'($urandom), 1'b1);
    endtask

    initial
    begin
        int phase_idx;
        rst_n               = 1'b0;
        chars_if.valid      = 1'b0;
        chars_if.text_char  = '0;
        chars_if.end_marker = 1'b0;
        runs_if.ready       = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = CFG_MAX_RUN;
        cfg_wr_data         = '0;
        lim_max             = MAX_RUN_RESET;
        lim_accept          = 1'b0;
        clear_decoder();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the register reset values
        gaps_on    = 1'b1;
        ready_mode = RDY_COIN;
        foreach (dir_rows[i])
            send_item(dir_rows[i]);
        drain();

        // random phases, each with its own settings, stall pattern and pacing;
        // the sender waits for every run before each settings change
        phase_idx = 0;
        while (text_items < TEXT_ITEMS)
        begin
            case (phase_idx)
                0: set_config(LEN_MAX, 1'b0);
                1: set_config('0, 1'b1);
                2: set_config('0, 1'b0);
                3: set_config(LEN_W'(300), 1'b1);
                default:
                begin
                    case ($urandom_range(0, 3))
                        0: set_config(LEN_W'($urandom_range(0, 300)), 1'($urandom));
                        1: set_config(LEN_W'($urandom_range(0, 20000)), 1'($urandom));
                        2: set_config(LEN_W'({$urandom, $urandom}), 1'($urandom));
                        default: set_config(MAX_RUN_RESET, 1'($urandom));
                    endcase
                end
            endcase
            ready_mode = ready_mode_e'($urandom_range(0, 3));
            gaps_on    = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(3, 8))
                gen_dump();
            drain();
            phase_idx++;
        end

        if (mismatch_cnt == 0 && run_expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
